@@ rtl/ncdf_pkg.sv @@
`default_nettype none
package ncdf_pkg;

  // Port field widths
  localparam int ZW  = 16;
  localparam int PW  = 17;

  // Datapath widths
  localparam int XW  = 31;  // z^2 in Q25, up to 2^30
  localparam int AXW = 34;  // a*x^2 in Q30
  localparam int NDW = 35;  // numerator / denominator in Q30
  localparam int QW  = 31;  // Q30 values up to and including one
  localparam int HW  = 26;  // fractional exponent f/16 in Q30
  localparam int NW  = 6;   // integer part of the exponent
  localparam int RW  = 61;  // square-root remainder and partial root
  localparam int MW  = 18;  // rounded magnitude before clamp

  // Pipeline layout
  localparam int DIV_ST  = 31;
  localparam int TAY_ST  = 6;
  localparam int SQ_ST   = 4;
  localparam int EXP_ST  = 21;  // e is zero after 21 steps of exp(-1)
  localparam int SQRT_ST = 31;
  localparam int S_DIV   = 3;
  localparam int S_U     = S_DIV + DIV_ST;
  localparam int S_T     = S_U + 1;
  localparam int S_SQ    = S_T + TAY_ST;
  localparam int S_E     = S_SQ + SQ_ST;
  localparam int S_RT    = S_E + EXP_ST;
  localparam int S_MAG   = S_RT + SQRT_ST;
  localparam int S_OUT   = S_MAG + 1;
  localparam int NST     = S_OUT + 1;

  // Constants
  localparam logic [QW-1:0] ONE_Q30    = 31'd1073741824;
  localparam logic [27:0]   A_Q30      = 28'd150337050;
  localparam logic [QW-1:0] FOURPI_Q30 = 31'd1367130551;
  localparam logic [28:0]   E1_Q30     = 29'd395007542;
  localparam logic [29:0]   RECIP5     = 30'd858993460;   // ceil(2^32 / 5)
  localparam logic [30:0]   RECIP3     = 31'd1431655766;  // ceil(2^32 / 3)
  localparam logic [PW-1:0] HALF_SCALE = 17'd51200;
  localparam logic [PW-1:0] FULL_SCALE = 17'd102400;
  localparam logic [47:0]   ROUND_HALF = 48'd536870912;

endpackage
`default_nettype wire

@@ rtl/ncdf_z_if.sv @@
`default_nettype none
interface ncdf_z_if;
  logic                          valid;
  logic                          ready;
  logic signed [ncdf_pkg::ZW-1:0] z_value;

  modport source (output valid, output z_value, input ready);
  modport sink   (input valid, input z_value, output ready);
endinterface
`default_nettype wire

@@ rtl/ncdf_pct_if.sv @@
`default_nettype none
interface ncdf_pct_if;
  logic                   valid;
  logic                   ready;
  logic [ncdf_pkg::PW-1:0] percentile;

  modport source (output valid, output percentile, input ready);
  modport sink   (input valid, input percentile, output ready);
endinterface
`default_nettype wire

@@ rtl/normal_cdf_percentile.sv @@
// Throughput: one beat per cycle; 31 restoring-divide stages, 21 exp(-1)
// multiply stages and 31 square-root stages set the depth.
// The whole pipeline stalls together while the output beat is not taken.
// Reset clears the stage valid bits only; data registers are not reset.
`default_nettype none
module normal_cdf_percentile (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ncdf_z_if.sink      z_i,
  ncdf_pct_if.source  pct_o
);

  logic                       en;
  logic [ncdf_pkg::NST-1:0]   vld_q;
  logic [ncdf_pkg::NST-1:0]   neg_q;

  assign en        = !vld_q[ncdf_pkg::S_OUT] || pct_o.ready;
  assign z_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[ncdf_pkg::NST-2:0], z_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg_q <= {neg_q[ncdf_pkg::NST-2:0], z_i.z_value[ncdf_pkg::ZW-1]};
    end
  end

  // Stage 0: |z| and its square
  logic [ncdf_pkg::ZW:0]   zext;
  logic [ncdf_pkg::ZW:0]   mabs;
  logic [33:0]             msq;
  logic [ncdf_pkg::XW-1:0] x_q [0:ncdf_pkg::S_U-1];

  assign zext = {z_i.z_value[ncdf_pkg::ZW-1], z_i.z_value};
  assign mabs = z_i.z_value[ncdf_pkg::ZW-1] ? (~zext + 17'd1) : zext;
  assign msq  = 34'(mabs) * 34'(mabs);

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q[0] <= msq[ncdf_pkg::XW-1:0];
    end
  end

  for (genvar i = 1; i < ncdf_pkg::S_U; i++) begin : g_xsh
    always_ff @(posedge clk_i) begin
      if (en) begin
        x_q[i] <= x_q[i-1];
      end
    end
  end

  // Stage 1: a*x^2
  logic [58:0]              ax2_prod;
  logic [ncdf_pkg::AXW-1:0] ax2_q;

  assign ax2_prod = 59'(x_q[0]) * 59'(ncdf_pkg::A_Q30);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax2_q <= ax2_prod[58:25];
    end
  end

  // Stage 2: numerator and denominator, seed the divider
  logic [ncdf_pkg::NDW-1:0] num;
  logic [ncdf_pkg::NDW-1:0] den;
  logic [ncdf_pkg::NDW-1:0] dr_q  [0:ncdf_pkg::DIV_ST-1];
  logic [ncdf_pkg::NDW-1:0] den_q [0:ncdf_pkg::DIV_ST-1];
  logic [ncdf_pkg::QW-1:0]  quo_q [1:ncdf_pkg::DIV_ST];
  logic                     n0_q;

  assign num = 35'(ncdf_pkg::FOURPI_Q30) + 35'(ax2_q);
  assign den = 35'(ncdf_pkg::ONE_Q30) + 35'(ax2_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      dr_q[0]  <= 35'(num[ncdf_pkg::NDW-1:1]);
      den_q[0] <= den;
      n0_q     <= num[0];
    end
  end

  // Restoring divide, one quotient bit per stage
  for (genvar k = 1; k <= ncdf_pkg::DIV_ST; k++) begin : g_div
    logic [ncdf_pkg::NDW:0]  sh;
    logic [ncdf_pkg::NDW:0]  diff;
    logic                    ge;
    logic [ncdf_pkg::QW-1:0] qprev;

    assign sh   = {dr_q[k-1], (k == 1) ? n0_q : 1'b0};
    assign diff = sh - {1'b0, den_q[k-1]};
    assign ge   = sh >= {1'b0, den_q[k-1]};

    if (k == 1) begin : g_first
      assign qprev = '0;
    end else begin : g_rest
      assign qprev = quo_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        quo_q[k] <= {qprev[ncdf_pkg::QW-2:0], ge};
      end
    end

    if (k < ncdf_pkg::DIV_ST) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en) begin
          dr_q[k]  <= ge ? diff[ncdf_pkg::NDW-1:0] : sh[ncdf_pkg::NDW-1:0];
          den_q[k] <= den_q[k-1];
        end
      end
    end
  end

  // Exponent u = X*r >> 31, split into integer and fraction
  logic [61:0]             u_prod;
  logic [ncdf_pkg::NW-1:0] n_q [ncdf_pkg::S_U:ncdf_pkg::S_RT-2];
  logic [ncdf_pkg::HW-1:0] h_q [ncdf_pkg::S_U:ncdf_pkg::S_U+ncdf_pkg::TAY_ST-1];

  assign u_prod = 62'(x_q[ncdf_pkg::S_U-1]) * 62'(quo_q[ncdf_pkg::DIV_ST]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_q[ncdf_pkg::S_U] <= u_prod[60:55];
      h_q[ncdf_pkg::S_U] <= {u_prod[54:31], 2'b00};
    end
  end

  for (genvar i = ncdf_pkg::S_U + 1; i <= ncdf_pkg::S_RT - 2; i++) begin : g_nsh
    always_ff @(posedge clk_i) begin
      if (en) begin
        n_q[i] <= n_q[i-1];
      end
    end
  end

  for (genvar i = ncdf_pkg::S_U + 1; i < ncdf_pkg::S_U + ncdf_pkg::TAY_ST; i++) begin : g_hsh
    always_ff @(posedge clk_i) begin
      if (en) begin
        h_q[i] <= h_q[i-1];
      end
    end
  end

  // Taylor series of exp(-h), nested form
  logic [55:0]             t5_prod;
  logic [23:0]             h5_q;
  logic [ncdf_pkg::QW-1:0] q5;
  logic [56:0]             p5_prod;
  logic [ncdf_pkg::HW-1:0] wa_q;
  logic [ncdf_pkg::QW-1:0] q4;
  logic [56:0]             p4_prod;
  logic [ncdf_pkg::HW-1:0] wb_q;
  logic [56:0]             t3_prod;
  logic [24:0]             wc_q;
  logic [ncdf_pkg::QW-1:0] q3;
  logic [56:0]             p3_prod;
  logic [ncdf_pkg::HW-1:0] wd_q;
  logic [ncdf_pkg::QW-1:0] q2;
  logic [56:0]             p2_prod;
  logic [ncdf_pkg::HW-1:0] we_q;

  assign t5_prod = 56'(h_q[ncdf_pkg::S_U]) * 56'(ncdf_pkg::RECIP5);
  assign q5      = ncdf_pkg::ONE_Q30 - 31'(h5_q);
  assign p5_prod = 57'(h_q[ncdf_pkg::S_U+1]) * 57'(q5);
  assign q4      = ncdf_pkg::ONE_Q30 - 31'(wa_q >> 2);
  assign p4_prod = 57'(h_q[ncdf_pkg::S_U+2]) * 57'(q4);
  assign t3_prod = 57'(wb_q) * 57'(ncdf_pkg::RECIP3);
  assign q3      = ncdf_pkg::ONE_Q30 - 31'(wc_q);
  assign p3_prod = 57'(h_q[ncdf_pkg::S_U+4]) * 57'(q3);
  assign q2      = ncdf_pkg::ONE_Q30 - 31'(wd_q >> 1);
  assign p2_prod = 57'(h_q[ncdf_pkg::S_U+5]) * 57'(q2);

  always_ff @(posedge clk_i) begin
    if (en) begin
      h5_q <= t5_prod[55:32];
      wa_q <= p5_prod[55:30];
      wb_q <= p4_prod[55:30];
      wc_q <= t3_prod[56:32];
      wd_q <= p3_prod[55:30];
      we_q <= p2_prod[55:30];
    end
  end

  // Raise to the 16th power, then apply exp(-1) once per integer unit
  logic [ncdf_pkg::QW-1:0] e_q [ncdf_pkg::S_SQ:ncdf_pkg::S_RT-1];

  for (genvar s = ncdf_pkg::S_SQ; s < ncdf_pkg::S_E; s++) begin : g_sq
    logic [ncdf_pkg::QW-1:0] ein;
    logic [61:0]             sq_prod;

    if (s == ncdf_pkg::S_SQ) begin : g_first
      assign ein = ncdf_pkg::ONE_Q30 - 31'(we_q);
    end else begin : g_rest
      assign ein = e_q[s-1];
    end

    assign sq_prod = 62'(ein) * 62'(ein);

    always_ff @(posedge clk_i) begin
      if (en) begin
        e_q[s] <= sq_prod[60:30];
      end
    end
  end

  for (genvar s = ncdf_pkg::S_E; s < ncdf_pkg::S_RT; s++) begin : g_e1
    logic [59:0] m_prod;

    assign m_prod = 60'(e_q[s-1]) * 60'(ncdf_pkg::E1_Q30);

    always_ff @(posedge clk_i) begin
      if (en) begin
        e_q[s] <= (n_q[s-1] > 6'(s - ncdf_pkg::S_E)) ? 31'(m_prod[59:30]) : e_q[s-1];
      end
    end
  end

  // Digit-by-digit square root of (1 - e) << 30
  logic [ncdf_pkg::QW-1:0] e_cl;
  logic [ncdf_pkg::RW-1:0] rem_q [ncdf_pkg::S_RT:ncdf_pkg::S_MAG-2];
  logic [ncdf_pkg::RW-1:0] res_q [ncdf_pkg::S_RT:ncdf_pkg::S_MAG-1];

  assign e_cl = (e_q[ncdf_pkg::S_RT-1] > ncdf_pkg::ONE_Q30) ? ncdf_pkg::ONE_Q30
                                                            : e_q[ncdf_pkg::S_RT-1];

  for (genvar s = ncdf_pkg::S_RT; s < ncdf_pkg::S_MAG; s++) begin : g_rt
    localparam logic [ncdf_pkg::RW-1:0] BIT =
      ncdf_pkg::RW'(1) << (2 * (ncdf_pkg::S_MAG - 1 - s));
    logic [ncdf_pkg::RW-1:0] rin;
    logic [ncdf_pkg::RW-1:0] sin;
    logic [ncdf_pkg::RW:0]   trial;
    logic                    take;

    if (s == ncdf_pkg::S_RT) begin : g_first
      assign rin = {ncdf_pkg::ONE_Q30 - e_cl, 30'd0};
      assign sin = '0;
    end else begin : g_rest
      assign rin = rem_q[s-1];
      assign sin = res_q[s-1];
    end

    assign trial = 62'(sin) + 62'(BIT);
    assign take  = {1'b0, rin} >= trial;

    always_ff @(posedge clk_i) begin
      if (en) begin
        res_q[s] <= take ? ((sin >> 1) + BIT) : (sin >> 1);
      end
    end

    if (s < ncdf_pkg::S_MAG - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en) begin
          rem_q[s] <= take ? (rin - trial[ncdf_pkg::RW-1:0]) : rin;
        end
      end
    end
  end

  // Scale erf to 50.0 and round
  logic [ncdf_pkg::QW-1:0] erf;
  logic [47:0]             mag_sum;
  logic [ncdf_pkg::MW-1:0] mag_raw;
  logic [ncdf_pkg::PW-1:0] mag_q;

  assign erf = (res_q[ncdf_pkg::S_MAG-1] > ncdf_pkg::RW'(ncdf_pkg::ONE_Q30))
               ? ncdf_pkg::ONE_Q30 : res_q[ncdf_pkg::S_MAG-1][ncdf_pkg::QW-1:0];
  assign mag_sum = 48'(erf) * 48'(ncdf_pkg::HALF_SCALE) + ncdf_pkg::ROUND_HALF;
  assign mag_raw = mag_sum[47:30];

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q <= (mag_raw > 18'(ncdf_pkg::HALF_SCALE)) ? ncdf_pkg::HALF_SCALE
                                                     : mag_raw[ncdf_pkg::PW-1:0];
    end
  end

  // Output register: fold in the sign and clamp
  logic [ncdf_pkg::MW-1:0] pct_raw;
  logic [ncdf_pkg::PW-1:0] pct_q;

  assign pct_raw = neg_q[ncdf_pkg::S_MAG] ? (18'(ncdf_pkg::HALF_SCALE) - 18'(mag_q))
                                          : (18'(ncdf_pkg::HALF_SCALE) + 18'(mag_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      pct_q <= (pct_raw > 18'(ncdf_pkg::FULL_SCALE)) ? ncdf_pkg::FULL_SCALE
                                                     : pct_raw[ncdf_pkg::PW-1:0];
    end
  end

  assign pct_o.valid      = vld_q[ncdf_pkg::S_OUT];
  assign pct_o.percentile = pct_q;

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pct_o.valid |-> pct_o.percentile <= ncdf_pkg::FULL_SCALE)
    else $error("percentile out of range");

  a_neg_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pct_o.valid && neg_q[ncdf_pkg::S_OUT] |-> pct_o.percentile <= ncdf_pkg::HALF_SCALE)
    else $error("negative score above the median");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pct_o.valid && !pct_o.ready |=> pct_o.valid && !z_i.ready || pct_o.ready)
    else $error("pipeline advanced while output stalled");

endmodule
`default_nettype wire

@@ sim/ncdf_checker.sv @@
`timescale 1ns / 1ps
module ncdf_checker (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   z_valid_i,
  input  logic                   z_ready_i,
  input  logic [ncdf_pkg::ZW-1:0] z_value_i,
  input  logic                   pct_valid_i,
  input  logic                   pct_ready_i,
  input  logic [ncdf_pkg::PW-1:0] percentile_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  localparam longint unsigned ONE  = 64'd1073741824;
  localparam longint unsigned ACO  = 64'd150337050;
  localparam longint unsigned FPI  = 64'd1367130551;
  localparam longint unsigned EM1  = 64'd395007542;
  localparam longint unsigned HALF = 64'd51200;
  localparam longint unsigned FULL = 64'd102400;

  logic [ncdf_pkg::PW-1:0] pct_expected_q[$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned decay(longint unsigned u);
    longint unsigned n, h, q, e;
    n = u >> 24;
    h = (u & 64'hFFFFFF) << 2;
    q = ONE - h / 5;
    q = ONE - ((h * q) >> 30) / 4;
    q = ONE - ((h * q) >> 30) / 3;
    q = ONE - ((h * q) >> 30) / 2;
    e = ONE - ((h * q) >> 30);
    for (int i = 0; i < 4; i++) e = (e * e) >> 30;
    for (longint unsigned i = 0; i < n && e != 0; i++) e = (e * EM1) >> 30;
    return e;
  endfunction

  function automatic logic [ncdf_pkg::PW-1:0] percentile_of(logic [ncdf_pkg::ZW-1:0] z);
    logic neg;
    longint unsigned m, sq, ax2, r, u, e, erfv, mag, res;
    neg = z[ncdf_pkg::ZW-1];
    m = neg ? (64'h10000 - z) : z;
    sq = m * m;
    ax2 = (ACO * sq) >> 25;
    r = ((FPI + ax2) << 30) / (ONE + ax2);
    u = (sq * r) >> 31;
    e = decay(u);
    if (e > ONE) e = ONE;
    erfv = int_sqrt((ONE - e) << 30);
    if (erfv > ONE) erfv = ONE;
    mag = (HALF * erfv + (64'd1 << 29)) >> 30;
    if (mag > HALF) mag = HALF;
    res = neg ? HALF - mag : HALF + mag;
    if (res > FULL) res = FULL;
    return res[ncdf_pkg::PW-1:0];
  endfunction

  assign pending_o = pct_expected_q.size();

  always @(posedge clk_i) begin
    logic [ncdf_pkg::PW-1:0] want;
    if (rst_ni) begin
      if (z_valid_i && z_ready_i) begin
        pct_expected_q = {pct_expected_q, percentile_of(z_value_i)};
      end
      if (pct_valid_i && pct_ready_i) begin
        if (pct_expected_q.size() == 0) begin
          $error("percentile beat with nothing expected: %0d", percentile_i);
          fail_count_o++;
        end else begin
          want = pct_expected_q.pop_front();
          if (percentile_i !== want) begin
            $error("percentile mismatch: expected %0d actual %0d", want, percentile_i);
            fail_count_o++;
          end
        end
      end
    end
  end
endmodule

@@ sim/normal_cdf_percentile_tb.sv @@
`timescale 1ns / 1ps
module normal_cdf_percentile_tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending;
  bit   idle_off = 1'b0;
  bit   hold_sink = 1'b0;

  ncdf_z_if   z_if ();
  ncdf_pct_if pct_if ();

  always #2 clk_i = ~clk_i;

  normal_cdf_percentile uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .z_i    (z_if.sink),
    .pct_o  (pct_if.source)
  );

  ncdf_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .z_valid_i    (z_if.valid),
    .z_ready_i    (z_if.ready),
    .z_value_i    (z_if.z_value),
    .pct_valid_i  (pct_if.valid),
    .pct_ready_i  (pct_if.ready),
    .percentile_i (pct_if.percentile),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  task automatic send_z(logic [ncdf_pkg::ZW-1:0] z);
    if (!idle_off && $urandom_range(0, 5) == 0) begin
      z_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    z_if.valid   <= 1'b1;
    z_if.z_value <= z;
    do @(posedge clk_i); while (!z_if.ready);
    @(negedge clk_i);
  endtask

  // Sink side: random stall bursts, plus one long hold-off.
  initial begin
    pct_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        pct_if.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_sink = 1'b0;
      end else if (!idle_off && $urandom_range(0, 5) == 0) begin
        pct_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk_i);
      end else begin
        pct_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [ncdf_pkg::ZW-1:0] directed[$] = '{16'h0000, 16'h8000, 16'h7FFF, 16'h0001,
      16'hFFFF, 16'h1000, 16'hF000, 16'h2000, 16'hE000, 16'h0800, 16'hF800, 16'h4000,
      16'hC000, 16'h5555, 16'hAAAA, 16'h3000, 16'hD000, 16'h8001};
    int k;
    z_if.valid = 1'b0;
    z_if.z_value = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (directed[i]) send_z(directed[i]);
    hold_sink = 1'b1;
    for (k = 0; k < 1250; k++) begin
      if (k == 1000) idle_off = 1'b1;
      // Most scores sit where the curve bends; some span the whole range.
      if ($urandom_range(0, 3) == 0) send_z(16'($urandom));
      else send_z(16'($signed($urandom_range(0, 32767)) - 16384));
    end
    z_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end
endmodule
